// ----- hdl/i2cms_pkg.sv -----
package i2cms_pkg;

    // Function codes of an input item.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Acknowledge modes after a read.
    localparam logic [1:0] ACKM_ACK  = 2'd0;
    localparam logic [1:0] ACKM_NAK  = 2'd1;
    localparam logic [1:0] ACKM_NONE = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_ACK     = 2'd0;
    localparam logic [1:0] STAT_NAK     = 2'd1;
    localparam logic [1:0] STAT_BADADDR = 2'd2;

    localparam logic [9:0] ADDR_MAX = 10'h7F;

    // Segment indexes where sequences branch or end.
    localparam logic [5:0] START_HDR_SEGS  = 6'd3;
    localparam logic [5:0] START_SEND_END  = 6'd38;
    localparam logic [5:0] START_STOP_BASE = 6'd39;
    localparam logic [5:0] START_STOP_END  = 6'd41;
    localparam logic [5:0] STOP_END        = 6'd2;
    localparam logic [5:0] SEND_BITS_SEGS  = 6'd32;
    localparam logic [5:0] WRITE_END       = 6'd35;
    localparam logic [5:0] READ_DATA_END   = 6'd24;
    localparam logic [5:0] READ_ACK_BASE   = 6'd25;
    localparam logic [5:0] READ_END        = 6'd28;
    localparam logic [5:0] PHASE_MAX       = 6'd42;

    localparam logic [0:0] REG_TPQ = 1'b0;

    typedef enum logic [1:0] {
        PIN_LOW  = 2'd0,
        PIN_HIGH = 2'd1,
        PIN_REL  = 2'd2
    } pin_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_RBIT = 2'd2,
        KIND_WBIT = 2'd3
    } kind_t;

    typedef struct packed {
        pin_t  sda;
        pin_t  scl;
        kind_t kind;
    } seg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] address;
        logic       read_not_write;
        logic [7:0] write_data;
        logic [1:0] ack_mode;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic [5:0] phase_step;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic       bus_started;
        logic [2:0] active_command;
        logic [1:0] saved_ack_mode;
        logic [1:0] last_status;
        pin_t       pin_sda;
        pin_t       pin_scl;
        logic [7:0] read_latch;
    } seq_state_t;

    typedef struct packed {
        logic [1:0] sda_drive;
        logic [1:0] scl_drive;
        logic       busy_res;
        logic       done_res;
        logic [1:0] ack_status;
        logic [7:0] read_data;
        logic       rejected;
    } result_t;

endpackage

// ----- hdl/i2cms_cfg_regs.sv -----
module i2cms_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] ticks_per_quarter
);
    import i2cms_pkg::*;

    logic [15:0] tpq_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg <= 16'd1;
        end
        else if (wr_en && paddr[2] == REG_TPQ)
        begin
            tpq_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TPQ)
        begin
            prdata = {16'd0, tpq_reg};
        end
    end

    assign ticks_per_quarter = tpq_reg;

endmodule

// ----- hdl/i2cms_seg_decode.sv -----
module i2cms_seg_decode (
    input  logic [2:0]       active_command,
    input  logic [5:0]       idx,
    input  logic             data_msb,
    input  logic [1:0]       saved_ack_mode,
    output i2cms_pkg::seg_t  seg
);
    import i2cms_pkg::*;

    function automatic seg_t send_seg(input logic [5:0] k, input logic b);
        seg_t s;
        logic [1:0] r;
        r = k[1:0];
        s.scl = (r == 2'd1 || r == 2'd2) ? PIN_HIGH : PIN_LOW;
        if (k < SEND_BITS_SEGS)
        begin
            s.sda  = b ? PIN_HIGH : PIN_LOW;
            s.kind = (r == 2'd3) ? KIND_WBIT : KIND_NONE;
        end
        else
        begin
            s.sda  = PIN_REL;
            s.kind = (r == 2'd1) ? KIND_ACK : KIND_NONE;
        end
        return s;
    endfunction

    function automatic seg_t stop_seg(input logic [5:0] j);
        seg_t s;
        s.kind = KIND_NONE;
        if (j == 6'd0)
        begin
            s.sda = PIN_LOW;
            s.scl = PIN_LOW;
        end
        else if (j == 6'd1)
        begin
            s.sda = PIN_LOW;
            s.scl = PIN_HIGH;
        end
        else
        begin
            s.sda = PIN_REL;
            s.scl = PIN_REL;
        end
        return s;
    endfunction

    logic [5:0] rd_x;
    logic [8:0] rd_prod;
    logic [2:0] rd_q;
    logic [5:0] rd_rem;
    logic [1:0] ack_j;

    // Slot within a read bit is (idx - 1) mod 3; x * 11 / 32 gives x / 3 for x up to 23.
    always_comb
    begin
        rd_x    = idx - 6'd1;
        rd_prod = 9'(rd_x) * 9'd11;
        rd_q    = rd_prod[7:5];
        rd_rem  = rd_x - 6'({rd_q, 1'b0}) - 6'(rd_q);
        ack_j   = 2'(idx - READ_ACK_BASE);
    end

    always_comb
    begin
        seg = '{sda: PIN_REL, scl: PIN_REL, kind: KIND_NONE};
        case (active_command)
            CMD_START:
            begin
                if (idx == 6'd0)
                begin
                    seg = '{sda: PIN_HIGH, scl: PIN_HIGH, kind: KIND_NONE};
                end
                else if (idx == 6'd1)
                begin
                    seg = '{sda: PIN_LOW, scl: PIN_HIGH, kind: KIND_NONE};
                end
                else if (idx == 6'd2)
                begin
                    seg = '{sda: PIN_LOW, scl: PIN_LOW, kind: KIND_NONE};
                end
                else if (idx < START_STOP_BASE)
                begin
                    seg = send_seg(idx - START_HDR_SEGS, data_msb);
                end
                else
                begin
                    seg = stop_seg(idx - START_STOP_BASE);
                end
            end
            CMD_STOP:
            begin
                seg = stop_seg(idx);
            end
            CMD_WRITE:
            begin
                seg = send_seg(idx, data_msb);
            end
            CMD_READ:
            begin
                if (idx == 6'd0)
                begin
                    seg = '{sda: PIN_REL, scl: PIN_LOW, kind: KIND_NONE};
                end
                else if (idx < READ_ACK_BASE)
                begin
                    if (rd_rem == 6'd2)
                    begin
                        seg = '{sda: PIN_REL, scl: PIN_LOW, kind: KIND_NONE};
                    end
                    else
                    begin
                        seg.sda  = PIN_REL;
                        seg.scl  = PIN_HIGH;
                        seg.kind = (rd_rem == 6'd0) ? KIND_RBIT : KIND_NONE;
                    end
                end
                else
                begin
                    seg.sda  = saved_ack_mode[0] ? PIN_HIGH : PIN_LOW;
                    seg.scl  = (ack_j == 2'd1 || ack_j == 2'd2) ? PIN_HIGH : PIN_LOW;
                    seg.kind = KIND_NONE;
                end
            end
            default:
            begin
                seg = '{sda: PIN_REL, scl: PIN_REL, kind: KIND_NONE};
            end
        endcase
    end

endmodule

// ----- hdl/i2cms_step.sv -----
module i2cms_step #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  i2cms_pkg::item_t               item,
    input  i2cms_pkg::seq_state_t          state_in,
    input  logic [TICK_COUNTER_BITS-1:0]   tick_in,
    input  logic [15:0]                    ticks_per_quarter,
    output i2cms_pkg::seq_state_t          state_out,
    output logic [TICK_COUNTER_BITS-1:0]   tick_out,
    output i2cms_pkg::result_t             result
);
    import i2cms_pkg::*;

    localparam int LW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

    logic [LW-1:0]                tpq_w;
    logic [LW-1:0]                mask_w;
    logic [LW-1:0]                limit_w;
    logic [TICK_COUNTER_BITS-1:0] limit;

    // The delay unit is at least one tick and at most what the counter can hold.
    always_comb
    begin
        tpq_w  = LW'(ticks_per_quarter);
        mask_w = LW'({TICK_COUNTER_BITS{1'b1}});
        if (ticks_per_quarter == 16'd0)
        begin
            limit_w = LW'(1);
        end
        else if (tpq_w > mask_w)
        begin
            limit_w = mask_w;
        end
        else
        begin
            limit_w = tpq_w;
        end
        limit = limit_w[TICK_COUNTER_BITS-1:0];
    end

    logic                         is_cmd;
    seq_state_t                   st_load;
    logic [TICK_COUNTER_BITS-1:0] tc_load;
    logic                         load_done;
    logic                         rej;

    assign is_cmd = item.func inside {[CMD_START:CMD_READ]};

    // Command launch while idle; a command that arrives while busy is rejected.
    always_comb
    begin
        st_load   = state_in;
        tc_load   = tick_in;
        load_done = 1'b0;
        rej       = 1'b0;
        if (state_in.phase_step == 6'd0)
        begin
            if (is_cmd)
            begin
                if (item.func == CMD_START && item.address > ADDR_MAX)
                begin
                    st_load.last_status = STAT_BADADDR;
                    load_done           = 1'b1;
                end
                else if (item.func == CMD_STOP && !state_in.bus_started)
                begin
                    load_done = 1'b1;
                end
                else
                begin
                    st_load.active_command = item.func;
                    st_load.phase_step     = 6'd1;
                    st_load.bit_count      = 4'd0;
                    tc_load                = '0;
                    case (item.func)
                        CMD_START:
                        begin
                            st_load.shift_byte = {item.address[6:0], item.read_not_write};
                        end
                        CMD_WRITE:
                        begin
                            st_load.shift_byte = item.write_data;
                        end
                        CMD_READ:
                        begin
                            st_load.shift_byte     = 8'd0;
                            st_load.saved_ack_mode = (item.ack_mode > ACKM_NAK) ? ACKM_NONE
                                                                                : item.ack_mode;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (is_cmd)
        begin
            rej = 1'b1;
        end
    end

    logic [5:0] idx;
    seg_t       seg;

    assign idx = st_load.phase_step - 6'd1;

    i2cms_seg_decode u_seg (
        .active_command (st_load.active_command),
        .idx            (idx),
        .data_msb       (st_load.shift_byte[7]),
        .saved_ack_mode (st_load.saved_ack_mode),
        .seg            (seg)
    );

    logic [TICK_COUNTER_BITS-1:0] tc_inc;
    logic                         fin;
    logic                         fin_done;

    always_comb
    begin
        state_out = st_load;
        tick_out  = tc_load;
        tc_inc    = tc_load + 1'b1;
        fin       = 1'b0;
        fin_done  = 1'b0;
        if (st_load.phase_step != 6'd0)
        begin
            if (tc_load == '0)
            begin
                state_out.pin_sda = seg.sda;
                state_out.pin_scl = seg.scl;
            end
            tick_out = tc_inc;
            if (tc_inc >= limit)
            begin
                tick_out = '0;
                case (seg.kind)
                    KIND_ACK:
                    begin
                        state_out.last_status = {1'b0, item.sda_sample};
                    end
                    KIND_RBIT:
                    begin
                        state_out.shift_byte = {st_load.shift_byte[6:0], item.sda_sample};
                        state_out.bit_count  = st_load.bit_count + 4'd1;
                    end
                    KIND_WBIT:
                    begin
                        state_out.shift_byte = {st_load.shift_byte[6:0], 1'b0};
                        state_out.bit_count  = st_load.bit_count + 4'd1;
                    end
                    default:
                    begin
                    end
                endcase
                case (st_load.active_command)
                    CMD_START:
                    begin
                        // After the address byte, a NAK rolls on into the stop segments.
                        if (idx == START_SEND_END)
                        begin
                            state_out.bus_started = 1'b1;
                            fin = (state_out.last_status == STAT_ACK);
                        end
                        else if (idx >= START_STOP_END)
                        begin
                            state_out.bus_started = 1'b0;
                            fin = 1'b1;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (idx >= STOP_END)
                        begin
                            state_out.bus_started = 1'b0;
                            fin = 1'b1;
                        end
                    end
                    CMD_WRITE:
                    begin
                        fin = (idx >= WRITE_END);
                    end
                    CMD_READ:
                    begin
                        if (idx == READ_DATA_END)
                        begin
                            state_out.read_latch = state_out.shift_byte;
                            fin = (st_load.saved_ack_mode == ACKM_NONE);
                        end
                        else if (idx >= READ_END)
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
                if (fin)
                begin
                    state_out.phase_step     = 6'd0;
                    state_out.active_command = CMD_NONE;
                    fin_done                 = 1'b1;
                end
                else
                begin
                    state_out.phase_step = st_load.phase_step + 6'd1;
                end
            end
        end
    end

    always_comb
    begin
        result.sda_drive  = state_out.pin_sda;
        result.scl_drive  = state_out.pin_scl;
        result.busy_res   = (state_out.phase_step != 6'd0);
        result.done_res   = load_done || fin_done;
        result.ack_status = state_out.last_status;
        result.read_data  = state_out.read_latch;
        result.rejected   = rej;
    end

endmodule

// ----- hdl/i2c_master_byte_sequencer_top.sv -----
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  func, address, read_not_write, write_data,
//                                         ack_mode, sda_sample
// out       output     out_valid/out_ready sda_drive, scl_drive, busy_res, done_res,
//                                         ack_status, read_data, rejected
// cfg       APB        psel/penable       ticks_per_quarter at byte address 0
//
// Each tick item is held in the input register and passes through the sequencer step
// logic into the result register, from which its result is offered; one item is taken
// every cycle while the result side does not stall. The step is one pass of the
// segment decoder and counter.
// Reset returns the sequencer to idle with both lines released and the delay at 1.
// A stall on the result side holds the input register; while it is full and stalled, in_ready drops.
module i2c_master_byte_sequencer_top #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [9:0]  address,
    input  logic        read_not_write,
    input  logic [7:0]  write_data,
    input  logic [1:0]  ack_mode,
    input  logic        sda_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  sda_drive,
    output logic [1:0]  scl_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [1:0]  ack_status,
    output logic [7:0]  read_data,
    output logic        rejected
);
    import i2cms_pkg::*;

    logic [15:0] ticks_per_quarter;

    i2cms_cfg_regs u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .ticks_per_quarter (ticks_per_quarter)
    );

    logic                         in_valid_reg;
    item_t                        item_reg;
    logic                         out_valid_reg;
    result_t                      result_reg;
    result_t                      result_next;
    seq_state_t                   state_reg;
    seq_state_t                   state_next;
    logic [TICK_COUNTER_BITS-1:0] tick_counter_reg;
    logic [TICK_COUNTER_BITS-1:0] tick_counter_next;
    logic                         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    i2cms_step #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_step (
        .item              (item_reg),
        .state_in          (state_reg),
        .tick_in           (tick_counter_reg),
        .ticks_per_quarter (ticks_per_quarter),
        .state_out         (state_next),
        .tick_out          (tick_counter_next),
        .result            (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{func: func, address: address, read_not_write: read_not_write,
                          write_data: write_data, ack_mode: ack_mode,
                          sda_sample: sda_sample};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase_step: 6'd0, bit_count: 4'd0, shift_byte: 8'd0,
                           bus_started: 1'b0, active_command: CMD_NONE,
                           saved_ack_mode: ACKM_NONE, last_status: STAT_ACK,
                           pin_sda: PIN_REL, pin_scl: PIN_REL, read_latch: 8'd0};
            tick_counter_reg <= '0;
        end
        else if (advance)
        begin
            state_reg        <= state_next;
            tick_counter_reg <= tick_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sda_drive  = result_reg.sda_drive;
    assign scl_drive  = result_reg.scl_drive;
    assign busy_res   = result_reg.busy_res;
    assign done_res   = result_reg.done_res;
    assign ack_status = result_reg.ack_status;
    assign read_data  = result_reg.read_data;
    assign rejected   = result_reg.rejected;

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(tick_counter_reg))
        else $error("sequencer state changed without an item");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.done_res |-> !result_next.busy_res)
        else $error("completed item still reports busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.rejected |-> state_reg.phase_step != 6'd0)
        else $error("command rejected while idle");

    a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase_step == 6'd0 |-> tick_counter_reg == '0)
        else $error("tick counter running while idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase_step <= PHASE_MAX)
        else $error("segment index beyond the longest sequence");

endmodule

// ----- sim/i2cms_tb_pkg.sv -----
package i2cms_tb_pkg;

    import i2cms_pkg::*;

    // Tracks the sequencer tick by tick and holds the results still owed by the block.
    class seq_scoreboard;
        logic [15:0] quarter_ticks;
        logic [5:0]  phase_step;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] tick_count;
        logic        bus_started;
        logic [2:0]  active_cmd;
        logic [1:0]  saved_ackm;
        logic [1:0]  last_status;
        pin_t        pin_sda;
        pin_t        pin_scl;
        logic [7:0]  read_latch;

        result_t     owed_results[$];
        int unsigned mismatches;
        int unsigned ticks_taken;
        int unsigned done_count;
        int unsigned reject_count;
        int unsigned nak_count;
        int unsigned badaddr_count;

        function new();
            quarter_ticks = 16'd1;
            phase_step    = '0;
            bit_count     = '0;
            shift_byte    = '0;
            tick_count    = '0;
            bus_started   = 1'b0;
            active_cmd    = CMD_NONE;
            saved_ackm    = ACKM_NONE;
            last_status   = STAT_ACK;
            pin_sda       = PIN_REL;
            pin_scl       = PIN_REL;
            read_latch    = '0;
            mismatches    = 0;
            ticks_taken   = 0;
            done_count    = 0;
            reject_count  = 0;
            nak_count     = 0;
            badaddr_count = 0;
        endfunction

        function void set_quarter(logic [15:0] value);
            quarter_ticks = value;
        endfunction

        function bit busy();
            return phase_step != 0;
        endfunction

        function bit bus_up();
            return bus_started;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function seg_t make_seg(pin_t sda, pin_t scl, kind_t kind);
            seg_t s;
            s.sda  = sda;
            s.scl  = scl;
            s.kind = kind;
            return s;
        endfunction

        // Eight data bits of four quarters each, then the four quarters of the ACK slot.
        function seg_t send_segment(int unsigned k);
            int unsigned j;
            pin_t        scl;
            if (k < SEND_BITS_SEGS) begin
                j   = k % 4;
                scl = (j == 1 || j == 2) ? PIN_HIGH : PIN_LOW;
                return make_seg(shift_byte[7] ? PIN_HIGH : PIN_LOW, scl,
                                (j == 3) ? KIND_WBIT : KIND_NONE);
            end
            j   = k - SEND_BITS_SEGS;
            scl = (j == 1 || j == 2) ? PIN_HIGH : PIN_LOW;
            return make_seg(PIN_REL, scl, (j == 1) ? KIND_ACK : KIND_NONE);
        endfunction

        function seg_t stop_segment(int unsigned j);
            if (j == 0)
                return make_seg(PIN_LOW, PIN_LOW, KIND_NONE);
            if (j == 1)
                return make_seg(PIN_LOW, PIN_HIGH, KIND_NONE);
            return make_seg(PIN_REL, PIN_REL, KIND_NONE);
        endfunction

        function seg_t segment_at(int unsigned idx);
            int unsigned r;
            pin_t        scl;
            case (active_cmd)
                CMD_START:
                begin
                    if (idx == 0)
                        return make_seg(PIN_HIGH, PIN_HIGH, KIND_NONE);
                    if (idx == 1)
                        return make_seg(PIN_LOW, PIN_HIGH, KIND_NONE);
                    if (idx == 2)
                        return make_seg(PIN_LOW, PIN_LOW, KIND_NONE);
                    if (idx < START_STOP_BASE)
                        return send_segment(idx - START_HDR_SEGS);
                    return stop_segment(idx - START_STOP_BASE);
                end
                CMD_STOP:
                    return stop_segment(idx);
                CMD_WRITE:
                    return send_segment(idx);
                CMD_READ:
                begin
                    if (idx == 0)
                        return make_seg(PIN_REL, PIN_LOW, KIND_NONE);
                    if (idx < READ_ACK_BASE) begin
                        r = (idx - 1) % 3;
                        if (r == 2)
                            return make_seg(PIN_REL, PIN_LOW, KIND_NONE);
                        return make_seg(PIN_REL, PIN_HIGH, (r == 0) ? KIND_RBIT : KIND_NONE);
                    end
                    r   = idx - READ_ACK_BASE;
                    scl = (r == 1 || r == 2) ? PIN_HIGH : PIN_LOW;
                    return make_seg(saved_ackm[0] ? PIN_HIGH : PIN_LOW, scl, KIND_NONE);
                end
                default:
                    return make_seg(PIN_REL, PIN_REL, KIND_NONE);
            endcase
        endfunction

        // Returns 1 when segment idx closes the running command.
        function bit segment_closes(int unsigned idx);
            case (active_cmd)
                CMD_START:
                begin
                    if (idx == START_SEND_END) begin
                        bus_started = 1'b1;
                        return last_status == STAT_ACK;
                    end
                    if (idx >= START_STOP_END) begin
                        bus_started = 1'b0;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                CMD_STOP:
                begin
                    if (idx >= STOP_END) begin
                        bus_started = 1'b0;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                CMD_WRITE:
                    return idx >= WRITE_END;
                CMD_READ:
                begin
                    if (idx == READ_DATA_END) begin
                        read_latch = shift_byte;
                        if (saved_ackm == ACKM_NONE)
                            return 1'b1;
                    end
                    return idx >= READ_END;
                end
                default:
                    return 1'b1;
            endcase
        endfunction

        function void accept_tick(item_t it);
            result_t     r;
            seg_t        s;
            bit          is_cmd;
            bit          done;
            bit          rej;
            int unsigned idx;
            int unsigned limit;
            is_cmd = it.func >= CMD_START && it.func <= CMD_READ;
            done   = 1'b0;
            rej    = 1'b0;
            limit  = (quarter_ticks == 0) ? 1 : quarter_ticks;

            if (phase_step == 0) begin
                if (is_cmd) begin
                    if (it.func == CMD_START && it.address > ADDR_MAX) begin
                        last_status = STAT_BADADDR;
                        done        = 1'b1;
                        badaddr_count++;
                    end else if (it.func == CMD_STOP && !bus_started) begin
                        done = 1'b1;
                    end else begin
                        active_cmd = it.func;
                        phase_step = 6'd1;
                        tick_count = '0;
                        bit_count  = '0;
                        if (it.func == CMD_START)
                            shift_byte = {it.address[6:0], it.read_not_write};
                        if (it.func == CMD_WRITE)
                            shift_byte = it.write_data;
                        if (it.func == CMD_READ) begin
                            shift_byte = '0;
                            saved_ackm = (it.ack_mode > ACKM_NAK) ? ACKM_NONE : it.ack_mode;
                        end
                    end
                end
            end else if (is_cmd) begin
                rej = 1'b1;
                reject_count++;
            end

            if (phase_step != 0) begin
                idx = phase_step - 1;
                s   = segment_at(idx);
                if (tick_count == 0) begin
                    pin_sda = s.sda;
                    pin_scl = s.scl;
                end
                tick_count = tick_count + 16'd1;
                if (tick_count >= limit) begin
                    tick_count = '0;
                    case (s.kind)
                        KIND_ACK:
                        begin
                            last_status = {1'b0, it.sda_sample};
                            if (it.sda_sample)
                                nak_count++;
                        end
                        KIND_RBIT:
                        begin
                            shift_byte = {shift_byte[6:0], it.sda_sample};
                            bit_count  = bit_count + 4'd1;
                        end
                        KIND_WBIT:
                        begin
                            shift_byte = {shift_byte[6:0], 1'b0};
                            bit_count  = bit_count + 4'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (segment_closes(idx)) begin
                        phase_step = '0;
                        active_cmd = CMD_NONE;
                        done       = 1'b1;
                    end else begin
                        phase_step = phase_step + 6'd1;
                    end
                end
            end

            if (done)
                done_count++;
            ticks_taken++;
            r.sda_drive  = pin_sda;
            r.scl_drive  = pin_scl;
            r.busy_res   = phase_step != 0;
            r.done_res   = done;
            r.ack_status = last_status;
            r.read_data  = read_latch;
            r.rejected   = rej;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0) begin
                $error("result arrived with no expectation waiting");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("sda_drive", want.sda_drive, got.sda_drive);
            compare_field("scl_drive", want.scl_drive, got.scl_drive);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("ack_status", want.ack_status, got.ack_status);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("rejected", want.rejected, got.rejected);
        endfunction
    endclass

endpackage

// ----- sim/tb_i2c_master_byte_sequencer_top.sv -----
module tb_i2c_master_byte_sequencer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;
    import i2cms_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned LONG_HOLD   = 80;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [9:0]  address;
    logic        read_not_write;
    logic [7:0]  write_data;
    logic [1:0]  ack_mode;
    logic        sda_sample;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  sda_drive;
    logic [1:0]  scl_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  ack_status;
    logic [7:0]  read_data;
    logic        rejected;

    seq_scoreboard sb;
    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_idle_pct = 0;
    bit            long_hold_req = 1'b0;
    int unsigned   cycle_count = 0;

    i2c_master_byte_sequencer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .address        (address),
        .read_not_write (read_not_write),
        .write_data     (write_data),
        .ack_mode       (ack_mode),
        .sda_sample     (sda_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sda_drive      (sda_drive),
        .scl_drive      (scl_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .ack_status     (ack_status),
        .read_data      (read_data),
        .rejected       (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at the cycle limit with %0d results outstanding", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready     = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{sda_drive, scl_drive, busy_res, done_res,
                              ack_status, read_data, rejected});
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        func           = it.func;
        address        = it.address;
        read_not_write = it.read_not_write;
        write_data     = it.write_data;
        ack_mode       = it.ack_mode;
        sda_sample     = it.sda_sample;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_tick(it);
        @(negedge clk);
    endtask

    function automatic item_t random_fields();
        item_t it;
        it.func           = CMD_NONE;
        it.address        = 10'($urandom_range(0, 1023));
        it.read_not_write = 1'($urandom_range(0, 1));
        it.write_data     = 8'($urandom_range(0, 255));
        it.ack_mode       = 2'($urandom_range(0, 3));
        it.sda_sample     = ($urandom_range(0, 99) < 30);
        return it;
    endfunction

    function automatic item_t make_cmd(logic [2:0] f, logic [9:0] addr, logic rnw,
                                       logic [7:0] data, logic [1:0] ackm);
        item_t it;
        it.func           = f;
        it.address        = addr;
        it.read_not_write = rnw;
        it.write_data     = data;
        it.ack_mode       = ackm;
        it.sda_sample     = 1'b0;
        return it;
    endfunction

    // SDA level for the ticks: 0 low, 1 high, anything else random.
    task automatic tick_until_idle(int sda_mode);
        item_t it;
        while (sb.busy())
        begin
            it            = random_fields();
            it.sda_sample = (sda_mode == 0) ? 1'b0 :
                            (sda_mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    task automatic run_cmd(item_t cmd, int sda_mode);
        send_item(cmd);
        tick_until_idle(sda_mode);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_quarter_ticks(logic [15:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_TPQ, 2'b00};
        pwdata  = {16'h0000, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.set_quarter(value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic directed_commands();
        item_t it;
        int    f;
        run_cmd(make_cmd(CMD_STOP, 10'd0, 1'b0, 8'h00, ACKM_ACK), 0);
        run_cmd(make_cmd(CMD_START, 10'd1023, 1'b1, 8'hFF, ACKM_NONE), 0);
        run_cmd(make_cmd(CMD_START, 10'd128, 1'b0, 8'h00, ACKM_ACK), 0);
        run_cmd(make_cmd(CMD_START, 10'd0, 1'b0, 8'h00, ACKM_ACK), 0);
        run_cmd(make_cmd(CMD_WRITE, 10'd0, 1'b0, 8'hFF, ACKM_ACK), 0);
        run_cmd(make_cmd(CMD_WRITE, 10'd1023, 1'b1, 8'h00, ACKM_ACK), 1);
        // A command arriving mid-write must be turned away.
        send_item(make_cmd(CMD_WRITE, 10'd0, 1'b0, 8'hA5, ACKM_ACK));
        send_item(make_cmd(CMD_START, 10'd5, 1'b0, 8'h00, ACKM_ACK));
        tick_until_idle(0);
        run_cmd(make_cmd(CMD_READ, 10'd0, 1'b0, 8'h00, ACKM_ACK), 1);
        run_cmd(make_cmd(CMD_READ, 10'd0, 1'b0, 8'h00, ACKM_NAK), 0);
        run_cmd(make_cmd(CMD_READ, 10'd0, 1'b0, 8'h00, ACKM_NONE), 2);
        run_cmd(make_cmd(CMD_READ, 10'd0, 1'b0, 8'h00, 2'd3), 2);
        for (f = 5; f <= 7; f++)
        begin
            it      = random_fields();
            it.func = 3'(f);
            send_item(it);
        end
        run_cmd(make_cmd(CMD_START, 10'd127, 1'b1, 8'h00, ACKM_ACK), 0);
        run_cmd(make_cmd(CMD_STOP, 10'd0, 1'b0, 8'h00, ACKM_ACK), 0);
        drain_results();
        write_quarter_ticks(16'd0);
        // An address NAK makes the block issue its own stop.
        run_cmd(make_cmd(CMD_START, 10'h055, 1'b0, 8'h00, ACKM_ACK), 1);
        run_cmd(make_cmd(CMD_WRITE, 10'd0, 1'b0, 8'h3C, ACKM_ACK), 2);
        run_cmd(make_cmd(CMD_READ, 10'd0, 1'b0, 8'h00, ACKM_ACK), 2);
        run_cmd(make_cmd(CMD_STOP, 10'd0, 1'b0, 8'h00, ACKM_ACK), 0);
        drain_results();
    endtask

    // Mostly well-formed transactions (start, reads and writes, stop) with noise mixed in.
    task automatic random_traffic(int unsigned target);
        item_t       it;
        int unsigned counted;
        int unsigned pick;
        bit          counts;
        counted = 0;
        while (counted < target)
        begin
            it   = random_fields();
            pick = $urandom_range(0, 99);
            if (!sb.busy()) begin
                if (pick < 8) begin
                    it.func = 3'($urandom_range(0, 7));
                end else if (!sb.bus_up() || pick >= 90) begin
                    it.func = CMD_START;
                    if (pick >= 18 && pick < 95)
                        it.address = 10'($urandom_range(0, 127));
                end else if (pick < 45) begin
                    it.func = CMD_WRITE;
                end else if (pick < 75) begin
                    it.func = CMD_READ;
                end else begin
                    it.func = CMD_STOP;
                end
            end else if (pick < 6) begin
                it.func = 3'($urandom_range(CMD_START, CMD_READ));
            end else if (pick < 12) begin
                it.func = 3'($urandom_range(5, 7));
            end
            counts = sb.busy() || (it.func >= CMD_START && it.func <= CMD_READ);
            send_item(it);
            if (counts)
                counted++;
        end
        tick_until_idle(2);
        drain_results();
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        func           = CMD_NONE;
        address        = '0;
        read_not_write = 1'b0;
        write_data     = '0;
        ack_mode       = ACKM_ACK;
        sda_sample     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_commands();

        // A longer delay unit, exercised on a stop so the run stays short.
        write_quarter_ticks(16'd1);
        run_cmd(make_cmd(CMD_START, 10'h02A, 1'b0, 8'h00, ACKM_ACK), 0);
        drain_results();
        write_quarter_ticks(16'd8);
        run_cmd(make_cmd(CMD_STOP, 10'd0, 1'b0, 8'h00, ACKM_ACK), 2);
        drain_results();

        write_quarter_ticks(16'd1);
        tx_idle_pct = 25;
        rx_idle_pct = 56;
        random_traffic(125);

        write_quarter_ticks(16'd2);
        tx_idle_pct = 56;
        rx_idle_pct = 25;
        random_traffic(125);

        write_quarter_ticks(16'd1);
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b1;
        random_traffic(125);

        repeat (10) @(negedge clk);
        $display("Checked %0d ticks: %0d commands completed, %0d rejected while busy",
                 sb.ticks_taken, sb.done_count, sb.reject_count);
        $display("Saw %0d NAKs and %0d bad addresses over delay units 0, 1, 2 and 8",
                 sb.nak_count, sb.badaddr_count);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/i2cms_pkg.sv
hdl/i2cms_cfg_regs.sv
hdl/i2cms_seg_decode.sv
hdl/i2cms_step.sv
hdl/i2c_master_byte_sequencer_top.sv
sim/i2cms_tb_pkg.sv
sim/tb_i2c_master_byte_sequencer_top.sv
